// ===== design/assert_macros.svh =====
// Assertion macros shared by the leased event queue RTL.
// Depends on nothing; simulation builds get checks, synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle
`define LEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("leq assertion failed");

// Check that a condition implies another in the next cycle
`define LEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("leq assertion failed");

`else

`define LEQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/leq_pkg.sv =====
// Shared types, constants and codes for the leased event queue.
// Used by every module and interface of the block; depends on nothing.
package leq_pkg;

    // Ring geometry
    localparam int QUEUE_DEPTH = 12;
    localparam int MAX_OUT     = 12;
    localparam int CAP_MAX     = (QUEUE_DEPTH < MAX_OUT) ? QUEUE_DEPTH : MAX_OUT;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int LIM_W       = $clog2(MAX_OUT + 1);

    // Field widths
    localparam int OP_W     = 3;
    localparam int TIME_W   = 32;
    localparam int SCORE_W  = 8;
    localparam int REQ_W    = 8;
    localparam int STATUS_W = 2;
    localparam int SEC_W    = 16;
    localparam int CAP_W    = 4;

    // Configuration port
    localparam int NUM_REGS = 4;
    localparam int ADDR_W   = $clog2(4 * NUM_REGS);
    localparam int DATA_W   = 32;

    // Register reset values
    localparam logic             ALARMS_RESET = 1'b1;
    localparam logic [SEC_W-1:0] LEASE_RESET  = 16'd3600;
    localparam logic [SEC_W-1:0] IDLE_RESET   = 16'd120;
    localparam logic [CAP_W-1:0] CAP_RESET    = 4'd6;

    typedef enum logic [1:0] {
        REG_ALARMS = 2'd0,
        REG_LEASE  = 2'd1,
        REG_IDLE   = 2'd2,
        REG_CAP    = 2'd3
    } reg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_MOTION = 3'd0,
        OP_CREATE = 3'd1,
        OP_PULL   = 3'd2,
        OP_RENEW  = 3'd3,
        OP_UNSUB  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_LEASE = 2'd1,
        ST_DISABLED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_READ,
        S_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic             alarms_enabled;
        logic [SEC_W-1:0] lease_seconds;
        logic [SEC_W-1:0] idle_timeout_seconds;
        logic [CAP_W-1:0] pull_cap;
    } cfg_t;

    typedef struct packed {
        logic               active;
        logic [SCORE_W-1:0] score;
        logic [TIME_W-1:0]  stamp;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic rd;
        logic emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic drain;
        logic last_emit;
    } dp_stat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                has_event;
        logic                event_active_out;
        logic [SCORE_W-1:0]  event_score_out;
        logic [TIME_W-1:0]   event_time;
        logic [TIME_W-1:0]   termination_time;
        logic                replaced_previous;
        logic                overwrote_oldest;
        logic                last;
    } result_t;

endpackage

// ===== design/leq_if.sv =====
// Valid/ready channel interfaces for the leased event queue input and result beats.
// Depends on leq_pkg for field widths.
interface leq_in_if;
    logic                         valid;
    logic                         ready;
    logic [leq_pkg::OP_W-1:0]     operation;
    logic [leq_pkg::TIME_W-1:0]   current_time;
    logic                         event_active;
    logic [leq_pkg::SCORE_W-1:0]  event_score;
    logic [leq_pkg::REQ_W-1:0]    requested_limit;

    modport source (
        output valid, operation, current_time, event_active, event_score, requested_limit,
        input  ready
    );
    modport sink (
        input  valid, operation, current_time, event_active, event_score, requested_limit,
        output ready
    );
endinterface

interface leq_out_if;
    logic                         valid;
    logic                         ready;
    logic [leq_pkg::STATUS_W-1:0] status;
    logic                         has_event;
    logic                         event_active_out;
    logic [leq_pkg::SCORE_W-1:0]  event_score_out;
    logic [leq_pkg::TIME_W-1:0]   event_time;
    logic [leq_pkg::TIME_W-1:0]   termination_time;
    logic                         replaced_previous;
    logic                         overwrote_oldest;
    logic                         last;

    modport source (
        output valid, status, has_event, event_active_out, event_score_out, event_time,
               termination_time, replaced_previous, overwrote_oldest, last,
        input  ready
    );
    modport sink (
        input  valid, status, has_event, event_active_out, event_score_out, event_time,
               termination_time, replaced_previous, overwrote_oldest, last,
        output ready
    );
endinterface

// ===== design/leq_cfg.sv =====
// Configuration register file behind the APB-style port.
// Depends on leq_pkg for register layout and reset values.
module leq_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [leq_pkg::ADDR_W-1:0]   paddr,
    input  logic [leq_pkg::DATA_W-1:0]   pwdata,
    output logic [leq_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output leq_pkg::cfg_t                cfg
);

    leq_pkg::cfg_t     cfg_reg;
    leq_pkg::cfg_t     cfg_next;
    leq_pkg::reg_idx_t idx;
    logic              wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = leq_pkg::reg_idx_t'(paddr[leq_pkg::ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // Pick the register addressed by the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                leq_pkg::REG_ALARMS: cfg_next.alarms_enabled = pwdata[0];
                leq_pkg::REG_LEASE:
                    cfg_next.lease_seconds = pwdata[leq_pkg::SEC_W-1:0];
                leq_pkg::REG_IDLE:
                    cfg_next.idle_timeout_seconds = pwdata[leq_pkg::SEC_W-1:0];
                leq_pkg::REG_CAP:    cfg_next.pull_cap = pwdata[leq_pkg::CAP_W-1:0];
            endcase
        end
    end

    // Return the addressed register, zero-extended
    always_comb
    begin
        unique case (idx)
            leq_pkg::REG_ALARMS:
                prdata = leq_pkg::DATA_W'(cfg_reg.alarms_enabled);
            leq_pkg::REG_LEASE:
                prdata = leq_pkg::DATA_W'(cfg_reg.lease_seconds);
            leq_pkg::REG_IDLE:
                prdata = leq_pkg::DATA_W'(cfg_reg.idle_timeout_seconds);
            leq_pkg::REG_CAP:
                prdata = leq_pkg::DATA_W'(cfg_reg.pull_cap);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarms_enabled       <= leq_pkg::ALARMS_RESET;
            cfg_reg.lease_seconds        <= leq_pkg::LEASE_RESET;
            cfg_reg.idle_timeout_seconds <= leq_pkg::IDLE_RESET;
            cfg_reg.pull_cap             <= leq_pkg::CAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/leq_ctrl.sv =====
// Controller state machine: sequences capture, evaluation and ring drain.
// Depends on leq_pkg for the state enum and the command/status structs.
module leq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  leq_pkg::dp_stat_t   stat,
    output leq_pkg::dp_cmd_t    cmd
);

    leq_pkg::ctrl_state_t state_reg;
    leq_pkg::ctrl_state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            leq_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = leq_pkg::S_EVAL;
            end
            leq_pkg::S_EVAL:
            begin
                if (stat.out_free)
                    state_next = stat.drain ? leq_pkg::S_READ : leq_pkg::S_IDLE;
            end
            leq_pkg::S_READ:
                state_next = leq_pkg::S_EMIT;
            leq_pkg::S_EMIT:
            begin
                if (stat.out_free)
                    state_next = stat.last_emit ? leq_pkg::S_IDLE : leq_pkg::S_READ;
            end
            default:
                state_next = leq_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        in_ready    = (state_reg == leq_pkg::S_IDLE);
        cmd.capture = (state_reg == leq_pkg::S_IDLE) && in_valid;
        cmd.eval    = (state_reg == leq_pkg::S_EVAL) && stat.out_free;
        cmd.rd      = (state_reg == leq_pkg::S_READ);
        cmd.emit    = (state_reg == leq_pkg::S_EMIT) && stat.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= leq_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/leq_dp.sv =====
// Datapath: lease registers, event ring memory, pull drain counter, result register.
// Depends on leq_pkg; driven by commands from leq_ctrl.
module leq_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  leq_pkg::cfg_t                 cfg,
    input  leq_pkg::dp_cmd_t              cmd,
    output leq_pkg::dp_stat_t             stat,
    input  logic [leq_pkg::OP_W-1:0]      in_operation,
    input  logic [leq_pkg::TIME_W-1:0]    in_current_time,
    input  logic                          in_event_active,
    input  logic [leq_pkg::SCORE_W-1:0]   in_event_score,
    input  logic [leq_pkg::REQ_W-1:0]     in_requested_limit,
    output logic                          out_valid,
    input  logic                          out_ready,
    output leq_pkg::result_t              out_res
);

    localparam int QD = leq_pkg::QUEUE_DEPTH;

    // Captured input beat
    logic [leq_pkg::OP_W-1:0]    op_reg;
    logic [leq_pkg::TIME_W-1:0]  now_reg;
    logic                        act_reg;
    logic [leq_pkg::SCORE_W-1:0] score_reg;
    logic [leq_pkg::REQ_W-1:0]   req_reg;

    // Lease and ring state
    logic                        lease_valid_reg, lease_valid_next;
    logic [leq_pkg::TIME_W-1:0]  lease_end_reg, lease_end_next;
    logic [leq_pkg::TIME_W-1:0]  last_pull_reg, last_pull_next;
    logic [leq_pkg::IDX_W-1:0]   head_reg, head_next;
    logic [leq_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [leq_pkg::LIM_W-1:0]   remain_reg, remain_next;

    // Ring memory
    leq_pkg::entry_t             ring_mem [QD];
    leq_pkg::entry_t             rd_reg;
    leq_pkg::entry_t             wr_entry;
    logic                        mem_we;
    logic [leq_pkg::IDX_W-1:0]   waddr;

    // Result register
    logic                        out_valid_reg, out_valid_next;
    leq_pkg::result_t            res_reg;
    leq_pkg::result_t            res_next;
    logic                        load;

    // Evaluation terms
    logic [leq_pkg::TIME_W:0]    end_sum;
    logic [leq_pkg::TIME_W-1:0]  sat_end;
    logic [leq_pkg::TIME_W-1:0]  gap;
    logic                        alive;
    logic                        full;
    logic [leq_pkg::SUM_W-1:0]   hc_sum;
    logic [leq_pkg::SUM_W-1:0]   hc_wrap;
    logic [leq_pkg::IDX_W:0]     head_inc;
    logic [leq_pkg::IDX_W-1:0]   head_adv;
    logic [leq_pkg::LIM_W-1:0]   cap_eff;
    logic [leq_pkg::LIM_W-1:0]   limit;
    logic                        op_known;
    logic                        has_result;

    // Saturated lease end
    assign end_sum = {1'b0, now_reg} + (leq_pkg::TIME_W + 1)'(cfg.lease_seconds);
    assign sat_end = end_sum[leq_pkg::TIME_W] ? '1 : end_sum[leq_pkg::TIME_W-1:0];

    // Lease check: end time and idle gap
    assign gap   = (now_reg >= last_pull_reg) ? (now_reg - last_pull_reg) : '0;
    assign alive = lease_valid_reg && !(now_reg > lease_end_reg)
                   && !(gap > leq_pkg::TIME_W'(cfg.idle_timeout_seconds));

    // Ring write slot; a full ring overwrites its head
    assign full    = (count_reg >= leq_pkg::CNT_W'(QD));
    assign hc_sum  = leq_pkg::SUM_W'(head_reg) + leq_pkg::SUM_W'(count_reg);
    assign hc_wrap = (hc_sum >= leq_pkg::SUM_W'(QD)) ? (hc_sum - leq_pkg::SUM_W'(QD)) : hc_sum;
    assign waddr   = full ? head_reg : hc_wrap[leq_pkg::IDX_W-1:0];

    // Head advanced by one with wrap
    assign head_inc = (leq_pkg::IDX_W + 1)'(head_reg) + 1'b1;
    assign head_adv = (head_inc == (leq_pkg::IDX_W + 1)'(QD)) ? '0
                                                              : head_inc[leq_pkg::IDX_W-1:0];

    // Clamp the cap, then apply the requested limit
    always_comb
    begin
        if (cfg.pull_cap == '0)
            cap_eff = leq_pkg::LIM_W'(1);
        else if (leq_pkg::LIM_W'(cfg.pull_cap) > leq_pkg::LIM_W'(leq_pkg::CAP_MAX))
            cap_eff = leq_pkg::LIM_W'(leq_pkg::CAP_MAX);
        else
            cap_eff = leq_pkg::LIM_W'(cfg.pull_cap);
        if (req_reg == '0 || req_reg >= leq_pkg::REQ_W'(cap_eff))
            limit = cap_eff;
        else
            limit = req_reg[leq_pkg::LIM_W-1:0];
    end

    assign op_known   = (op_reg <= leq_pkg::OP_W'(leq_pkg::OP_UNSUB));
    assign stat.drain = (op_reg == leq_pkg::OP_PULL) && alive && (count_reg != '0);
    assign has_result = op_known && !stat.drain;
    assign stat.last_emit = (remain_reg == leq_pkg::LIM_W'(1))
                            || (count_reg == leq_pkg::CNT_W'(1));
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign load = (cmd.eval && has_result) || cmd.emit;

    assign wr_entry.active = act_reg;
    assign wr_entry.score  = score_reg;
    assign wr_entry.stamp  = now_reg;

    // Evaluate one operation or hand out one ring entry
    always_comb
    begin
        lease_valid_next = lease_valid_reg;
        lease_end_next   = lease_end_reg;
        last_pull_next   = last_pull_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        remain_next      = remain_reg;
        mem_we           = 1'b0;
        res_next         = '0;
        res_next.status  = leq_pkg::ST_OK;
        res_next.last    = 1'b1;

        if (cmd.eval)
        begin
            unique case (op_reg)
                leq_pkg::OP_MOTION:
                begin
                    if (!cfg.alarms_enabled)
                        res_next.status = leq_pkg::ST_DISABLED;
                    else if (!lease_valid_reg)
                        res_next.status = leq_pkg::ST_NO_LEASE;
                    else
                    begin
                        mem_we = 1'b1;
                        res_next.overwrote_oldest = full;
                        if (full)
                        begin
                            head_next  = head_adv;
                            count_next = leq_pkg::CNT_W'(QD);
                        end
                        else
                            count_next = count_reg + 1'b1;
                    end
                end
                leq_pkg::OP_CREATE:
                begin
                    res_next.replaced_previous = lease_valid_reg;
                    res_next.termination_time  = sat_end;
                    lease_valid_next = 1'b1;
                    lease_end_next   = sat_end;
                    last_pull_next   = now_reg;
                    head_next        = '0;
                    count_next       = '0;
                end
                leq_pkg::OP_PULL:
                begin
                    if (!alive)
                    begin
                        lease_valid_next = 1'b0;
                        res_next.status  = leq_pkg::ST_NO_LEASE;
                    end
                    else
                    begin
                        last_pull_next = now_reg;
                        remain_next    = limit;
                        res_next.termination_time = lease_end_reg;
                    end
                end
                leq_pkg::OP_RENEW:
                begin
                    if (!alive)
                    begin
                        lease_valid_next = 1'b0;
                        res_next.status  = leq_pkg::ST_NO_LEASE;
                    end
                    else
                    begin
                        lease_end_next = sat_end;
                        res_next.termination_time = sat_end;
                    end
                end
                leq_pkg::OP_UNSUB:
                    lease_valid_next = 1'b0;
                default:
                    res_next.last = 1'b1;
            endcase
        end
        else if (cmd.emit)
        begin
            head_next   = head_adv;
            count_next  = count_reg - 1'b1;
            remain_next = remain_reg - 1'b1;
            res_next.has_event        = 1'b1;
            res_next.event_active_out = rd_reg.active;
            res_next.event_score_out  = rd_reg.score;
            res_next.event_time       = rd_reg.stamp;
            res_next.termination_time = lease_end_reg;
            res_next.last             = stat.last_emit;
        end
    end

    // Hold the result until the sink takes it
    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lease_valid_reg <= 1'b0;
            lease_end_reg   <= '0;
            last_pull_reg   <= '0;
            head_reg        <= '0;
            count_reg       <= '0;
            remain_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            lease_valid_reg <= lease_valid_next;
            lease_end_reg   <= lease_end_next;
            last_pull_reg   <= last_pull_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            remain_reg      <= remain_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers: captured beat and result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_operation;
            now_reg   <= in_current_time;
            act_reg   <= in_event_active;
            score_reg <= in_event_score;
            req_reg   <= in_requested_limit;
        end
        if (load)
            res_reg <= res_next;
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[waddr] <= wr_entry;
        if (cmd.rd)
            rd_reg <= ring_mem[head_reg];
    end

endmodule

// ===== design/leased_event_queue_unit.sv =====
// Leased event queue: one item is accepted, then evaluated once the result register is free.
// An accepted item is captured, then evaluated into the registered result; a pull that
// drains the ring emits its events after that, each by a read step and then an emit step,
// set by the single registered read port of the ring memory. No new item is accepted until then.
// Reset (rst_n low, asynchronous) clears lease, ring pointers and handshake state;
// ring contents are not cleared and no clearing pass runs, so items are taken at once.
`include "assert_macros.svh"

module leased_event_queue_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    leq_in_if.sink                      in_ch,
    leq_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [leq_pkg::ADDR_W-1:0]  paddr,
    input  logic [leq_pkg::DATA_W-1:0]  pwdata,
    output logic [leq_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    leq_pkg::cfg_t     cfg;
    leq_pkg::dp_cmd_t  cmd;
    leq_pkg::dp_stat_t stat;
    leq_pkg::result_t  res;
    logic              in_ready;

    leq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    leq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    leq_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .cmd                (cmd),
        .stat               (stat),
        .in_operation       (in_ch.operation),
        .in_current_time    (in_ch.current_time),
        .in_event_active    (in_ch.event_active),
        .in_event_score     (in_ch.event_score),
        .in_requested_limit (in_ch.requested_limit),
        .out_valid          (out_ch.valid),
        .out_ready          (out_ch.ready),
        .out_res            (res)
    );

    // Drive the channels
    assign in_ch.ready              = in_ready;
    assign out_ch.status            = res.status;
    assign out_ch.has_event         = res.has_event;
    assign out_ch.event_active_out  = res.event_active_out;
    assign out_ch.event_score_out   = res.event_score_out;
    assign out_ch.event_time        = res.event_time;
    assign out_ch.termination_time  = res.termination_time;
    assign out_ch.replaced_previous = res.replaced_previous;
    assign out_ch.overwrote_oldest  = res.overwrote_oldest;
    assign out_ch.last              = res.last;

    // An accepted beat blocks further input until it is evaluated
    `LEQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_ch.valid && in_ready, !in_ready)
    // A ring read is always followed by an emit step, never by new input
    `LEQ_ASSERT_NEXT(a_read_busy, clk, rst_n, cmd.rd, !in_ready)
    // A ring entry is emitted only into a free result register
    `LEQ_ASSERT_SAME(a_emit_free, clk, rst_n, cmd.emit, stat.out_free)
    // The controller issues at most one command per cycle
    `LEQ_ASSERT_SAME(a_cmd_onehot, clk, rst_n, 1'b1,
                     $onehot0({cmd.capture, cmd.eval, cmd.rd, cmd.emit}))

endmodule
